@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ src/pbo_pkg.sv @@
package pbo_pkg;

   localparam int PHASE_BITS_DEF  = 32;
   localparam int SINE_DEPTH_DEF  = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int SU_A_BITS    = 34;
   localparam int SU_B_BITS    = 32;
   localparam int SU_STEP_BITS = 6;
   localparam logic [SU_STEP_BITS-1:0] SU_FULL_STEPS = 6'd32;

   localparam logic [2:0] WAVE_SAW      = 3'd0;
   localparam logic [2:0] WAVE_PULSE    = 3'd1;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
   localparam logic [2:0] WAVE_SINE     = 3'd3;
   localparam logic [2:0] WAVE_SQUARE   = 3'd4;
   localparam logic [2:0] WAVE_NOISE    = 3'd5;

   localparam logic [1:0] CSR_WAVE_TYPE    = 2'd0;
   localparam logic [1:0] CSR_PHASE_INC    = 2'd1;
   localparam logic [1:0] CSR_PULSE_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_DRIFT_AMOUNT = 2'd3;

   localparam logic [15:0] PULSE_WIDTH_RESET = 16'h8000;
   localparam logic [SU_A_BITS-1:0] TWO_PI_Q30 = 34'd6746518852;
   localparam logic [SU_A_BITS-1:0] DIV_FIVE   = 34'd5;

   typedef struct packed {
      logic                    go;
      logic                    is_div;
      logic [SU_STEP_BITS-1:0] steps;
   } su_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } su_stat_type;

   function automatic logic [SU_A_BITS-1:0] horner_div(input logic [1:0] k);
      logic [SU_A_BITS-1:0] d;
      unique case (k)
         2'd0: d = 34'd72;
         2'd1: d = 34'd42;
         2'd2: d = 34'd20;
         2'd3: d = 34'd6;
      endcase
      return d;
   endfunction

endpackage

@@ src/pbo_serial_unit.sv @@
`include "assert_macros.svh"

module pbo_serial_unit (
   input  logic                                            clock,
   input  logic                                            reset,
   input  pbo_pkg::su_ctrl_type                            ctrl,
   input  logic [pbo_pkg::SU_A_BITS-1:0]                   opa,
   input  logic [pbo_pkg::SU_B_BITS-1:0]                   opb,
   input  logic [pbo_pkg::SU_B_BITS-1:0]                   opc,
   output pbo_pkg::su_stat_type                            stat,
   output logic [pbo_pkg::SU_A_BITS+pbo_pkg::SU_B_BITS-1:0] result
);
   import pbo_pkg::*;

   localparam int AW = SU_A_BITS;
   localparam int BW = SU_B_BITS;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    div_ff, div_in;
   logic [SU_STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]           a_ff, a_in;
   logic [AW-1:0]           hi_ff, hi_in;
   logic [BW-1:0]           lo_ff, lo_in;

   logic [AW:0]   sum;
   logic [AW:0]   shl;
   logic [AW+1:0] diff;
   logic          ge;

   always_comb begin
      sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      shl  = {hi_ff, lo_ff[BW-1]};
      diff = {1'b0, shl} - {2'b00, a_ff};
      ge   = !diff[AW+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;

      if (ctrl.go) begin
         busy_in = 1'b1;
         div_in  = ctrl.is_div;
         cnt_in  = ctrl.steps;
         a_in    = opa;
         hi_in   = ctrl.is_div ? AW'(opc) : '0;
         lo_in   = opb;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (div_ff) begin
            if (ge) begin
               hi_in = diff[AW-1:0];
               lo_in = {lo_ff[BW-2:0], 1'b1};
            end else begin
               hi_in = shl[AW-1:0];
               lo_in = {lo_ff[BW-2:0], 1'b0};
            end
         end else begin
            {hi_in, lo_in} = {sum, lo_ff[BW-1:1]};
         end
         if (cnt_ff == SU_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = {hi_ff, lo_ff};

   `ASSERT_CLK(a_go_idle, ctrl.go |-> !busy_ff, "operation started while busy")
   `ASSERT_CLK(a_done_last, (busy_ff && cnt_ff == SU_STEP_BITS'(1) && !ctrl.go) |=> done_ff, "missing done")
   `ASSERT_CLK(a_done_free, done_ff |-> !busy_ff, "done while busy")

endmodule

@@ src/polyblep_oscillator.sv @@
// Band-limited oscillator: one output sample for every input item.
// Input channel req_*: an item carries an external noise value and a drift
// noise value; it is taken when req_valid is high and req_stall low.
// Result channel rsp_*: one sample per item, held in an output register
// until taken (rsp_valid high, rsp_stall low). The next input item is
// accepted while that sample still waits.
// Config channel csr_*: always ready; write only while no item is in flight.
// Every multiply and divide runs through one shared bit-serial unit; a
// full operation runs 32 steps. Drift costs 2 full operations, each
// active polyBLEP edge 2, sine 10; every item ends with a divide by
// five. Saw checks one edge, pulse and square two; triangle, noise and
// unused codes check none. No new item is taken before the last sample
// is in the output register.
// Reset: phase cleared, wave saw, increment 0, pulse width one half, drift 0.
// A stalled result holds the last step until it is taken; the block then
// returns to accepting items.
`include "assert_macros.svh"

module polyblep_oscillator #(
   parameter int PHASE_BITS       = pbo_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = pbo_pkg::SINE_DEPTH_DEF,
   parameter int SAMPLE_BITS      = pbo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_noise_sample,
   input  logic signed [15:0]            req_drift_noise,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);
   import pbo_pkg::*;

   localparam int VW        = 36;
   localparam int SINE_LOG2 = $clog2(SINE_TABLE_DEPTH);
   localparam int XW        = SAMPLE_BITS + 34;
   localparam int YW        = SAMPLE_BITS + 2;
   localparam int RW        = SU_A_BITS + SU_B_BITS;

   localparam logic [VW-1:0] V_ONE      = 36'h1_0000_0000;
   localparam logic [XW-1:0] ROUND_HALF = XW'(64'd5 << 31);
   localparam logic [YW-1:0] Q_MAX      = YW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [YW-1:0] Q_NEG_MAX  = YW'(64'd1 << (SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] S_MAX = SAMPLE_BITS'(Q_MAX);
   localparam logic [SAMPLE_BITS-1:0] S_MIN = SAMPLE_BITS'(Q_NEG_MAX);

   typedef enum logic [4:0] {
      S_IDLE, S_DRIFT0, S_DRIFT0W, S_DRIFT1, S_DRIFT1W, S_WAVE,
      S_BLEP, S_BLEPDW, S_BLEPM, S_BLEPMW, S_BNEXT,
      S_SIN0, S_SIN0W, S_SIN1, S_SIN1W, S_SDIV, S_SDIVW, S_SMUL, S_SMULW,
      S_SFIN, S_SFINW, S_SCALE0, S_SCALE1, S_SCALEW, S_FIN
   } state_type;

   state_type               state_ff, state_in;
   logic [2:0]              wave_ff, wave_in;
   logic [31:0]             inc_ff, inc_in;
   logic [15:0]             pw_ff, pw_in;
   logic [15:0]             da_ff, da_in;
   logic [PHASE_BITS-1:0]   phase_acc_ff, phase_acc_in;
   logic [31:0]             t_ff, t_in;
   logic [31:0]             t2_ff, t2_in;
   logic [15:0]             ns_ff, ns_in;
   logic [15:0]             dn_ff, dn_in;
   logic [30:0]             mag_ff, mag_in;
   logic [VW-1:0]           v_ff, v_in;
   logic [31:0]             x_ff, x_in;
   logic                    bmode_ff, bmode_in;
   logic                    bidx_ff, bidx_in;
   logic                    bone_ff, bone_in;
   logic                    bneg_ff, bneg_in;
   logic [30:0]             a_ff, a_in;
   logic [31:0]             a2_ff, a2_in;
   logic [31:0]             u_ff, u_in;
   logic [30:0]             p_ff, p_in;
   logic [1:0]              k_ff, k_in;
   logic                    sneg_ff, sneg_in;
   logic [VW-1:0]           absv_ff, absv_in;
   logic                    vneg_ff, vneg_in;
   logic [YW-1:0]           q_ff, q_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;

   su_ctrl_type             su_ctrl;
   su_stat_type             su_stat;
   logic [SU_A_BITS-1:0]    su_opa;
   logic [SU_B_BITS-1:0]    su_opb;
   logic [SU_B_BITS-1:0]    su_opc;
   logic [RW-1:0]           su_res;

   logic [31:0]             t_cur;
   logic [31:0]             inc_eff;
   logic [PHASE_BITS-1:0]   step_ph;
   logic [16:0]             dn_abs;
   logic [31:0]             delta;
   logic [31:0]             tb;
   logic                    b_lo, b_hi;
   logic [VW-1:0]           bx, bh, bval;
   logic [31:0]             f, r, w, tri_d;
   logic [VW-1:0]           s_val;
   logic [XW-1:0]           xs;
   logic [YW-1:0]           y;
   logic                    req_accept;

   if (PHASE_BITS >= 32) begin : g_wide
      assign t_cur   = phase_acc_ff[PHASE_BITS-1 -: 32];
      assign step_ph = PHASE_BITS'(inc_eff) << (PHASE_BITS - 32);
   end else begin : g_narrow
      assign t_cur   = {phase_acc_ff, {(32 - PHASE_BITS){1'b0}}};
      assign step_ph = inc_eff[31 -: PHASE_BITS];
   end

   pbo_serial_unit u_su (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (su_ctrl),
      .opa    (su_opa),
      .opb    (su_opb),
      .opc    (su_opc),
      .stat   (su_stat),
      .result (su_res)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

   always_comb begin
      dn_abs  = dn_ff[15] ? (17'd0 - {1'b1, dn_ff}) : {1'b0, dn_ff};
      delta   = su_res[62:31];
      inc_eff = dn_ff[15] ? (inc_ff - delta) : (inc_ff + delta);
      tb      = bidx_ff ? t2_ff : t_ff;
      b_lo    = tb < inc_ff;
      b_hi    = ({1'b0, tb} + {1'b0, inc_ff}) > 33'h1_0000_0000;
      bx      = {3'b000, x_ff, 1'b0};
      bh      = {4'b0000, su_res[63:32]};
      bval    = bmode_ff ? (bh - bx + V_ONE) : (bx - bh - V_ONE);
      f       = {t_ff[31 -: SINE_LOG2], {(32 - SINE_LOG2){1'b0}}};
      unique case (f[31:30])
         2'd0: r = f;
         2'd1: r = 32'h8000_0000 - f;
         2'd2: r = f - 32'h8000_0000;
         2'd3: r = 32'd0 - f;
      endcase
      w       = {pw_ff, 16'h0000};
      tri_d   = t_ff[31] ? {1'b0, t_ff[30:0]} : (32'h8000_0000 - t_ff);
      s_val   = {2'b00, su_res[61:30], 2'b00};
      xs      = (XW'(absv_ff) << (SAMPLE_BITS - 1)) + ROUND_HALF;
      y       = xs[XW-1:32];
   end

   always_comb begin
      su_ctrl.go     = 1'b0;
      su_ctrl.is_div = 1'b0;
      su_ctrl.steps  = SU_FULL_STEPS;
      su_opa         = '0;
      su_opb         = '0;
      su_opc         = '0;

      state_in     = state_ff;
      wave_in      = wave_ff;
      inc_in       = inc_ff;
      pw_in        = pw_ff;
      da_in        = da_ff;
      phase_acc_in = phase_acc_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      ns_in        = ns_ff;
      dn_in        = dn_ff;
      mag_in       = mag_ff;
      v_in         = v_ff;
      x_in         = x_ff;
      bmode_in     = bmode_ff;
      bidx_in      = bidx_ff;
      bone_in      = bone_ff;
      bneg_in      = bneg_ff;
      a_in         = a_ff;
      a2_in        = a2_ff;
      u_in         = u_ff;
      p_in         = p_ff;
      k_in         = k_ff;
      sneg_in      = sneg_ff;
      absv_in      = absv_ff;
      vneg_in      = vneg_ff;
      q_in         = q_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_WAVE_TYPE:    wave_in = csr_wdata[2:0];
            CSR_PHASE_INC:    inc_in  = csr_wdata;
            CSR_PULSE_WIDTH:  pw_in   = csr_wdata[15:0];
            CSR_DRIFT_AMOUNT: da_in   = csr_wdata[15:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               t_in     = t_cur;
               ns_in    = req_noise_sample;
               dn_in    = req_drift_noise;
               state_in = S_DRIFT0;
            end
         end
         S_DRIFT0: begin
            su_ctrl.go = 1'b1;
            su_opa     = SU_A_BITS'(dn_abs);
            su_opb     = SU_B_BITS'(da_ff);
            state_in   = S_DRIFT0W;
         end
         S_DRIFT0W: begin
            if (su_stat.done) begin
               mag_in   = su_res[30:0];
               state_in = S_DRIFT1;
            end
         end
         S_DRIFT1: begin
            su_ctrl.go = 1'b1;
            su_opa     = SU_A_BITS'(inc_ff);
            su_opb     = {1'b0, mag_ff};
            state_in   = S_DRIFT1W;
         end
         S_DRIFT1W: begin
            if (su_stat.done) begin
               phase_acc_in = phase_acc_ff + step_ph;
               state_in     = S_WAVE;
            end
         end
         S_WAVE: begin
            bidx_in = 1'b0;
            bone_in = 1'b0;
            bneg_in = 1'b0;
            unique case (wave_ff)
               WAVE_SAW: begin
                  v_in     = {3'b000, t_ff, 1'b0} - V_ONE;
                  bone_in  = 1'b1;
                  bneg_in  = 1'b1;
                  state_in = S_BLEP;
               end
               WAVE_PULSE: begin
                  t2_in    = t_ff - w;
                  v_in     = (t_ff < w) ? V_ONE : (VW'(0) - V_ONE);
                  state_in = S_BLEP;
               end
               WAVE_SQUARE: begin
                  t2_in    = {~t_ff[31], t_ff[30:0]};
                  v_in     = t_ff[31] ? (VW'(0) - V_ONE) : V_ONE;
                  state_in = S_BLEP;
               end
               WAVE_TRIANGLE: begin
                  v_in     = V_ONE - {2'b00, tri_d, 2'b00};
                  state_in = S_SCALE0;
               end
               WAVE_SINE: begin
                  state_in = S_SIN0;
               end
               WAVE_NOISE: begin
                  v_in     = {{3{ns_ff[15]}}, ns_ff, 17'd0};
                  state_in = S_SCALE0;
               end
               default: begin
                  v_in     = '0;
                  state_in = S_SCALE0;
               end
            endcase
         end
         S_BLEP: begin
            priority if (b_lo) begin
               su_ctrl.go     = 1'b1;
               su_ctrl.is_div = 1'b1;
               su_opa         = SU_A_BITS'(inc_ff);
               su_opc         = tb;
               bmode_in       = 1'b0;
               state_in       = S_BLEPDW;
            end else if (b_hi) begin
               su_ctrl.go     = 1'b1;
               su_ctrl.is_div = 1'b1;
               su_opa         = SU_A_BITS'(inc_ff);
               su_opc         = 32'd0 - tb;
               bmode_in       = 1'b1;
               state_in       = S_BLEPDW;
            end else begin
               state_in = S_BNEXT;
            end
         end
         S_BLEPDW: begin
            if (su_stat.done) begin
               x_in     = su_res[31:0];
               state_in = S_BLEPM;
            end
         end
         S_BLEPM: begin
            su_ctrl.go = 1'b1;
            su_opa     = SU_A_BITS'(x_ff);
            su_opb     = x_ff;
            state_in   = S_BLEPMW;
         end
         S_BLEPMW: begin
            if (su_stat.done) begin
               v_in     = (bidx_ff || bneg_ff) ? (v_ff - bval) : (v_ff + bval);
               state_in = S_BNEXT;
            end
         end
         S_BNEXT: begin
            if (bone_ff || bidx_ff) begin
               state_in = S_SCALE0;
            end else begin
               bidx_in  = 1'b1;
               state_in = S_BLEP;
            end
         end
         S_SIN0: begin
            su_ctrl.go = 1'b1;
            su_opa     = TWO_PI_Q30;
            su_opb     = r;
            sneg_in    = f[31];
            state_in   = S_SIN0W;
         end
         S_SIN0W: begin
            if (su_stat.done) begin
               a_in     = su_res[62:32];
               state_in = S_SIN1;
            end
         end
         S_SIN1: begin
            su_ctrl.go = 1'b1;
            su_opa     = SU_A_BITS'(a_ff);
            su_opb     = {1'b0, a_ff};
            state_in   = S_SIN1W;
         end
         S_SIN1W: begin
            if (su_stat.done) begin
               a2_in    = su_res[61:30];
               u_in     = su_res[61:30];
               k_in     = 2'd0;
               state_in = S_SDIV;
            end
         end
         S_SDIV: begin
            su_ctrl.go     = 1'b1;
            su_ctrl.is_div = 1'b1;
            su_opa         = horner_div(k_ff);
            su_opb         = u_ff;
            state_in       = S_SDIVW;
         end
         S_SDIVW: begin
            if (su_stat.done) begin
               p_in = 31'h4000_0000 - su_res[30:0];
               if (k_ff == 2'd3) begin
                  state_in = S_SFIN;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_SMUL;
               end
            end
         end
         S_SMUL: begin
            su_ctrl.go = 1'b1;
            su_opa     = SU_A_BITS'(a2_ff);
            su_opb     = {1'b0, p_ff};
            state_in   = S_SMULW;
         end
         S_SMULW: begin
            if (su_stat.done) begin
               u_in     = su_res[61:30];
               state_in = S_SDIV;
            end
         end
         S_SFIN: begin
            su_ctrl.go = 1'b1;
            su_opa     = SU_A_BITS'(a_ff);
            su_opb     = {1'b0, p_ff};
            state_in   = S_SFINW;
         end
         S_SFINW: begin
            if (su_stat.done) begin
               v_in     = sneg_ff ? (VW'(0) - s_val) : s_val;
               state_in = S_SCALE0;
            end
         end
         S_SCALE0: begin
            absv_in  = v_ff[VW-1] ? (VW'(0) - v_ff) : v_ff;
            vneg_in  = v_ff[VW-1];
            state_in = S_SCALE1;
         end
         S_SCALE1: begin
            su_ctrl.go     = 1'b1;
            su_ctrl.is_div = 1'b1;
            su_ctrl.steps  = SU_STEP_BITS'(YW);
            su_opa         = DIV_FIVE;
            su_opb         = {y, {(SU_B_BITS - YW){1'b0}}};
            state_in       = S_SCALEW;
         end
         S_SCALEW: begin
            if (su_stat.done) begin
               q_in     = su_res[YW-1:0];
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (vneg_ff) begin
                  sample_in = (q_ff > Q_NEG_MAX) ? S_MIN : SAMPLE_BITS'(YW'(0) - q_ff);
               end else begin
                  sample_in = (q_ff > Q_MAX) ? S_MAX : SAMPLE_BITS'(q_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wave_ff      <= WAVE_SAW;
         inc_ff       <= '0;
         pw_ff        <= PULSE_WIDTH_RESET;
         da_ff        <= '0;
         phase_acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wave_ff      <= wave_in;
         inc_ff       <= inc_in;
         pw_ff        <= pw_in;
         da_ff        <= da_in;
         phase_acc_ff <= phase_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff      <= t_in;
      t2_ff     <= t2_in;
      ns_ff     <= ns_in;
      dn_ff     <= dn_in;
      mag_ff    <= mag_in;
      v_ff      <= v_in;
      x_ff      <= x_in;
      bmode_ff  <= bmode_in;
      bidx_ff   <= bidx_in;
      bone_ff   <= bone_in;
      bneg_ff   <= bneg_in;
      a_ff      <= a_in;
      a2_ff     <= a2_in;
      u_ff      <= u_in;
      p_ff      <= p_in;
      k_ff      <= k_in;
      sneg_ff   <= sneg_in;
      absv_ff   <= absv_in;
      vneg_ff   <= vneg_in;
      q_ff      <= q_in;
      sample_ff <= sample_in;
   end

   `ASSERT_CLK(a_accept_starts, req_accept |=> state_ff == S_DRIFT0, "item not started")
   `ASSERT_CLK(a_fin_holds, (state_ff == S_FIN && rsp_valid_ff && rsp_stall) |=> state_ff == S_FIN, "result overwritten")
   `ASSERT_CLK(a_phase_step, (!$past(reset) && !$stable(phase_acc_ff)) |-> $past(state_ff) == S_DRIFT1W, "phase moved outside update")

endmodule
